@@ rtl/rgb_ls_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rgb_ls_pkg;

    // Pixel store depth and the widths that follow from it.
    localparam int MAX_LEDS   = 256;
    localparam int LED_AW     = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int NUM_LEDS_W = 9;
    localparam int CNT_W      = ($clog2(MAX_LEDS + 1) > NUM_LEDS_W) ?
                                $clog2(MAX_LEDS + 1) : NUM_LEDS_W;

    localparam int PIX_W   = 24;
    localparam int BITPOS_W = 5;
    localparam int TICK_W  = 10;
    localparam int FUNC_W  = 3;
    localparam int IDX_W   = 8;
    localparam int CHAN_W  = 8;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 10;

    localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 10'd58;
    localparam logic [TICK_W-1:0] ONE_LOW_RST   = 10'd12;
    localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 10'd23;
    localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 10'd40;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK    = 3'd0,
        FN_SET     = 3'd1,
        FN_SET_ALL = 3'd2,
        FN_ALL_ON  = 3'd3,
        FN_CLEAR   = 3'd4,
        FN_SHOW    = 3'd5
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_LEDS  = 3'd0,
        CFG_ONE_HIGH  = 3'd1,
        CFG_ONE_LOW   = 3'd2,
        CFG_ZERO_HIGH = 3'd3,
        CFG_ZERO_LOW  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FILL_COLOUR = 2'd0,
        FILL_ONES   = 2'd1,
        FILL_ZERO   = 2'd2
    } t_fill;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  write_px;
        logic  fill_start;
        t_fill fill_kind;
        logic  fill_step;
        logic  show_start;
        logic  fetch;
        logic  tick;
        logic  emit;
        logic  rej;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_range;
        logic count_zero;
        logic fill_last;
        logic led_next;
        logic show_end;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/rgb_ls_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rgb_ls_ctrl
    import rgb_ls_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire t_dp_stat          i_stat,
    output logic                   busy,
    output t_dp_cmd                o_cmd
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_FILL  = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_PRIME = 7'b0010000,
        S_FETCH = 7'b0100000,
        S_SHOW  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_func  func;
    logic   is_cmd;

    assign func   = t_func'(i_func);
    assign busy   = !((r_state == S_IDLE) || (r_state == S_SHOW));
    assign is_cmd = (func == FN_SET) || (func == FN_SET_ALL) || (func == FN_ALL_ON) ||
                    (func == FN_CLEAR) || (func == FN_SHOW);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.fill_kind = FILL_ZERO;
        case (r_state)
            S_CLEAR: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.emit = 1'b1;
                    case (func)
                        FN_SET: begin
                            if (i_stat.in_range) begin
                                o_cmd.write_px = 1'b1;
                            end else begin
                                o_cmd.rej = 1'b1;
                            end
                        end
                        FN_SET_ALL, FN_ALL_ON, FN_CLEAR: begin
                            if (func == FN_SET_ALL) begin
                                o_cmd.fill_kind = FILL_COLOUR;
                            end else if (func == FN_ALL_ON) begin
                                o_cmd.fill_kind = FILL_ONES;
                            end
                            if (!i_stat.count_zero) begin
                                o_cmd.fill_start = 1'b1;
                                n_state          = S_FILL;
                            end
                        end
                        FN_SHOW: begin
                            if (!i_stat.count_zero) begin
                                o_cmd.emit       = 1'b0;
                                o_cmd.show_start = 1'b1;
                                n_state          = S_LOAD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_PRIME;
            end
            S_PRIME: begin
                o_cmd.tick = 1'b1;
                o_cmd.emit = 1'b1;
                if (i_stat.show_end) begin
                    n_state = S_IDLE;
                end else if (i_stat.led_next) begin
                    n_state = S_FETCH;
                end else begin
                    n_state = S_SHOW;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_SHOW;
            end
            S_SHOW: begin
                if (start) begin
                    o_cmd.tick = 1'b1;
                    o_cmd.emit = 1'b1;
                    o_cmd.rej  = is_cmd;
                    if (i_stat.show_end) begin
                        n_state = S_IDLE;
                    end else if (i_stat.led_next) begin
                        n_state = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rgb_ls_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rgb_ls_dp
    import rgb_ls_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    input  wire logic [IDX_W-1:0]     i_led_index,
    input  wire logic [CHAN_W-1:0]    i_red,
    input  wire logic [CHAN_W-1:0]    i_green,
    input  wire logic [CHAN_W-1:0]    i_blue,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DW-1:0]    i_cfg_data,
    output logic                      o_valid,
    output logic                      o_data_line,
    output logic                      o_busy_res,
    output logic                      o_rejected
);

    // Configuration registers.
    logic [NUM_LEDS_W-1:0] r_num_leds;
    logic [TICK_W-1:0]     r_one_high;
    logic [TICK_W-1:0]     r_one_low;
    logic [TICK_W-1:0]     r_zero_high;
    logic [TICK_W-1:0]     r_zero_low;

    // Pixel store and its registered read data.
    logic [PIX_W-1:0] r_mem [MAX_LEDS];
    logic [PIX_W-1:0] r_rd;

    // Fill sweep.
    logic [PIX_W-1:0]  r_fill_colour;
    logic [CNT_W-1:0]  r_fill_cnt;
    logic [LED_AW-1:0] r_fill_ptr;

    // Show timing.
    logic [LED_AW-1:0]   r_led_pos;
    logic [BITPOS_W-1:0] r_bit_pos;
    logic                r_phase;
    logic [TICK_W-1:0]   r_tick;

    // Result registers.
    logic r_valid;
    logic r_line;
    logic r_busy;
    logic r_rej;

    logic [CNT_W-1:0]  count;
    logic [PIX_W-1:0]  colour;
    logic [PIX_W-1:0]  n_fill_colour;
    logic              cur_bit;
    logic [TICK_W-1:0] len_raw;
    logic [TICK_W-1:0] len;
    logic              phase_done;
    logic              led_done;
    logic              last_led;
    logic              wr_en;
    logic [LED_AW-1:0] wr_addr;
    logic [PIX_W-1:0]  wr_data;

    assign count  = (CNT_W'(r_num_leds) > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) :
                    CNT_W'(r_num_leds);
    assign colour = {i_red, i_green, i_blue};

    always_comb begin
        case (i_cmd.fill_kind)
            FILL_COLOUR: n_fill_colour = colour;
            FILL_ONES:   n_fill_colour = '1;
            default:     n_fill_colour = '0;
        endcase
    end

    assign cur_bit = r_rd[BITPOS_W'(PIX_W - 1) - r_bit_pos];

    always_comb begin
        case ({cur_bit, r_phase})
            2'b00:   len_raw = r_zero_high;
            2'b01:   len_raw = r_zero_low;
            2'b10:   len_raw = r_one_high;
            default: len_raw = r_one_low;
        endcase
    end

    assign len        = (len_raw == '0) ? TICK_W'(1) : len_raw;
    assign phase_done = ({1'b0, r_tick} + (TICK_W + 1)'(1)) >= {1'b0, len};
    assign led_done   = phase_done && r_phase && (r_bit_pos == BITPOS_W'(PIX_W - 1));
    assign last_led   = (CNT_W'(r_led_pos) + CNT_W'(1)) >= count;

    always_comb begin
        o_stat.in_range   = CNT_W'(i_led_index) < count;
        o_stat.count_zero = (count == '0);
        o_stat.fill_last  = (CNT_W'(r_fill_ptr) + CNT_W'(1)) >= r_fill_cnt;
        o_stat.led_next   = led_done && !last_led;
        o_stat.show_end   = led_done && last_led;
    end

    // One write port shared by single pixel writes and the fill sweep.
    assign wr_en   = i_cmd.write_px || i_cmd.fill_step;
    assign wr_addr = i_cmd.write_px ? LED_AW'(i_led_index) : r_fill_ptr;
    assign wr_data = i_cmd.write_px ? colour : r_fill_colour;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.fetch) begin
            r_rd <= r_mem[r_led_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_leds  <= '0;
            r_one_high  <= ONE_HIGH_RST;
            r_one_low   <= ONE_LOW_RST;
            r_zero_high <= ZERO_HIGH_RST;
            r_zero_low  <= ZERO_LOW_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_LEDS:  r_num_leds  <= i_cfg_data[NUM_LEDS_W-1:0];
                CFG_ONE_HIGH:  r_one_high  <= i_cfg_data[TICK_W-1:0];
                CFG_ONE_LOW:   r_one_low   <= i_cfg_data[TICK_W-1:0];
                CFG_ZERO_HIGH: r_zero_high <= i_cfg_data[TICK_W-1:0];
                CFG_ZERO_LOW:  r_zero_low  <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // After reset the sweep is primed to clear the whole store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_colour <= '0;
            r_fill_cnt    <= CNT_W'(MAX_LEDS);
            r_fill_ptr    <= '0;
        end else if (i_cmd.fill_start) begin
            r_fill_colour <= n_fill_colour;
            r_fill_cnt    <= count;
            r_fill_ptr    <= '0;
        end else if (i_cmd.fill_step) begin
            r_fill_ptr <= r_fill_ptr + LED_AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_pos <= '0;
            r_bit_pos <= '0;
            r_phase   <= 1'b0;
            r_tick    <= '0;
        end else if (i_cmd.show_start) begin
            r_led_pos <= '0;
            r_bit_pos <= '0;
            r_phase   <= 1'b0;
            r_tick    <= '0;
        end else if (i_cmd.tick) begin
            if (phase_done) begin
                r_tick <= '0;
                if (!r_phase) begin
                    r_phase <= 1'b1;
                end else begin
                    r_phase <= 1'b0;
                    if (r_bit_pos == BITPOS_W'(PIX_W - 1)) begin
                        r_bit_pos <= '0;
                        if (last_led) begin
                            r_led_pos <= '0;
                        end else begin
                            r_led_pos <= r_led_pos + LED_AW'(1);
                        end
                    end else begin
                        r_bit_pos <= r_bit_pos + BITPOS_W'(1);
                    end
                end
            end else begin
                r_tick <= r_tick + TICK_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_line  <= 1'b0;
            r_busy  <= 1'b0;
            r_rej   <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            r_line  <= i_cmd.emit && i_cmd.tick && !r_phase;
            r_busy  <= i_cmd.emit && i_cmd.tick;
            r_rej   <= i_cmd.emit && i_cmd.rej;
        end
    end

    assign o_valid     = r_valid;
    assign o_data_line = r_line;
    assign o_busy_res  = r_busy;
    assign o_rejected  = r_rej;

endmodule

`default_nettype wire

@@ rtl/rgb_led_strip_serializer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Serial driver for a chain of RGB LEDs on a one-wire data line. Each start
// pulse taken while busy is low is one transaction and one tick of the line
// timing; its result (line level, show flag, rejection flag) appears on the
// result ports for a single cycle with o_valid high and cannot be held off.
// Most transactions give their result in the cycle after they are taken. The
// exceptions come from the single-ported pixel store: a show command holds
// busy through the load and prime states while the first colour is read,
// and its result is registered from the prime state; each further LED of a
// show holds busy in the fetch state for its colour read. The set all, all
// on and clear all commands hold busy while the store is swept over the
// shown LEDs, one entry per cycle. After reset the whole store is cleared
// by the same sweep, which keeps busy high until it ends; configuration
// writes are taken throughout.
module rgb_led_strip_serializer_core
    import rgb_ls_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [FUNC_W-1:0]    i_func,
    input  wire logic [IDX_W-1:0]     i_led_index,
    input  wire logic [CHAN_W-1:0]    i_red,
    input  wire logic [CHAN_W-1:0]    i_green,
    input  wire logic [CHAN_W-1:0]    i_blue,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DW-1:0]    i_cfg_data,
    output logic                      o_valid,
    output logic                      o_data_line,
    output logic                      o_busy_res,
    output logic                      o_rejected
);

    // The controller sequences commands, sweeps and the show; the datapath
    // owns the pixel store, the timing counters and the result registers.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    rgb_ls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_stat  (dp_stat),
        .busy    (busy),
        .o_cmd   (dp_cmd)
    );

    rgb_ls_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_led_index (i_led_index),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_data_line (o_data_line),
        .o_busy_res  (o_busy_res),
        .o_rejected  (o_rejected)
    );

endmodule

`default_nettype wire

@@ rtl/rgb_ls_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rgb_ls_checker
    import rgb_ls_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic [FUNC_W-1:0] i_func,
    input wire logic              o_valid,
    input wire logic              o_data_line,
    input wire logic              o_busy_res,
    input wire logic              o_rejected
);

    // The clearing sweep must hold off transactions straight after reset.
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low in the cycle after reset");

    // Every transaction other than a show answers in the next cycle.
    a_prompt_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func != FN_SHOW)) |=> o_valid)
        else $error("no result one cycle after a non-show transaction");

    // Result fields are quiet between results.
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> (!o_data_line && !o_busy_res && !o_rejected))
        else $error("result fields active without o_valid");

    // The line is only driven high by a show.
    a_line_in_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_data_line |-> o_busy_res)
        else $error("data line high outside a show");

endmodule

bind rgb_led_strip_serializer_core rgb_ls_checker u_rgb_ls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_func      (i_func),
    .o_valid     (o_valid),
    .o_data_line (o_data_line),
    .o_busy_res  (o_busy_res),
    .o_rejected  (o_rejected)
);

`default_nettype wire

@@ tb/rgb_led_strip_serializer_core_tb.sv @@
`timescale 1ns / 1ps

module rgb_led_strip_serializer_core_tb;
    import rgb_ls_pkg::*;

    // Function codes 6 and 7 have no meaning and must behave as a plain tick.
    localparam logic [FUNC_W-1:0]    FN_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0]    FN_SPARE_7 = 3'd7;
    // Register indexes above the last real register are decoded as nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [CFG_DW-1:0]    TICKS_MAX    = 10'h3FF;

    localparam int RANDOM_ITEMS = 1700;
    // The slowest legal run is every transaction waiting out the longest
    // gap and a full sweep of the store.
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int TAIL_CYCLES  = 16;

    // One result of the block: the line level and the two flags.
    typedef struct packed {
        logic data_line;
        logic show_busy;
        logic rejected;
    } t_strip_res;

    // A row of the directed plan is either a register write or one
    // transaction, optionally with its result written out by hand.
    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DW-1:0]    reg_data;
        logic [FUNC_W-1:0]    fn;
        logic [IDX_W-1:0]     idx;
        logic [PIX_W-1:0]     colour;
        bit                   known;
        t_strip_res           want;
    } t_plan_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [FUNC_W-1:0]    i_func;
    logic [IDX_W-1:0]     i_led_index;
    logic [CHAN_W-1:0]    i_red;
    logic [CHAN_W-1:0]    i_green;
    logic [CHAN_W-1:0]    i_blue;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DW-1:0]    i_cfg_data;
    logic                 o_valid;
    logic                 o_data_line;
    logic                 o_busy_res;
    logic                 o_rejected;

    rgb_led_strip_serializer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_led_index (i_led_index),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .o_data_line (o_data_line),
        .o_busy_res  (o_busy_res),
        .o_rejected  (o_rejected)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the strip state: the pixel store, the position of a running
    // show within its LED, bit and pulse, the LED count and the four timing registers.
    logic [PIX_W-1:0]      pix_mem [MAX_LEDS];
    bit                    show_on;
    int unsigned           led_pos;
    int unsigned           bit_pos;
    bit                    phase_lo;
    int unsigned           tick_cnt;
    logic [NUM_LEDS_W-1:0] m_num_leds;
    logic [TICK_W-1:0]     m_one_hi;
    logic [TICK_W-1:0]     m_one_lo;
    logic [TICK_W-1:0]     m_zero_hi;
    logic [TICK_W-1:0]     m_zero_lo;

    t_strip_res  pending_levels [$];
    t_plan_row   test_plan [$];
    int unsigned mismatches;
    int unsigned cycles;

    // A count above the depth of the store is taken as the full store.
    function automatic int unsigned shown_leds();
        return (m_num_leds > MAX_LEDS) ? MAX_LEDS : int'(m_num_leds);
    endfunction

    // Length of one half of a bit; a register holding zero still gives a
    // pulse of one tick.
    function automatic int unsigned pulse_len(input logic bit_val, input bit low_half);
        logic [TICK_W-1:0] t;
        if (bit_val)
            t = low_half ? m_one_lo : m_one_hi;
        else
            t = low_half ? m_zero_lo : m_zero_hi;
        return (t == '0) ? 1 : int'(t);
    endfunction

    task automatic fill_leds(input logic [PIX_W-1:0] colour, input int unsigned count);
        for (int i = 0; i < count; i++)
            pix_mem[i] = colour;
    endtask

    // Works out one tick of the strip. The command is handled against the
    // show state as it stood at the start of the tick, and only then does a
    // running show drive the line and move its timing on, so a show drives
    // its first high tick in the very tick of its command.
    task automatic predict_strip_tick(input logic [FUNC_W-1:0] fn,
                                      input logic [IDX_W-1:0] idx,
                                      input logic [PIX_W-1:0] colour,
                                      output t_strip_res res);
        int unsigned count;
        int unsigned pos;
        logic        cur_bit;
        count = shown_leds();
        res = '0;
        if (fn >= FN_SET && fn <= FN_SHOW) begin
            if (show_on) begin
                res.rejected = 1'b1;
            end else begin
                case (fn)
                    FN_SET: begin
                        if (idx < count)
                            pix_mem[idx] = colour;
                        else
                            res.rejected = 1'b1;
                    end
                    FN_SET_ALL: fill_leds(colour, count);
                    FN_ALL_ON:  fill_leds('1, count);
                    FN_CLEAR:   fill_leds('0, count);
                    default: begin
                        // An empty strip has nothing to show and the
                        // command is quietly dropped.
                        if (count != 0) begin
                            show_on  = 1'b1;
                            led_pos  = 0;
                            bit_pos  = 0;
                            phase_lo = 1'b0;
                            tick_cnt = 0;
                        end
                    end
                endcase
            end
        end
        if (show_on) begin
            pos = (led_pos < MAX_LEDS) ? led_pos : 0;
            cur_bit = pix_mem[pos][PIX_W - 1 - (bit_pos % PIX_W)];
            res.show_busy = 1'b1;
            res.data_line = !phase_lo;
            if (tick_cnt + 1 >= pulse_len(cur_bit, phase_lo)) begin
                tick_cnt = 0;
                if (!phase_lo) begin
                    phase_lo = 1'b1;
                end else begin
                    phase_lo = 1'b0;
                    bit_pos++;
                    if (bit_pos >= PIX_W) begin
                        bit_pos = 0;
                        // The count is read afresh, so a shorter strip
                        // written during a show cuts it short.
                        if (count == 0 || led_pos + 1 >= count) begin
                            show_on = 1'b0;
                            led_pos = 0;
                        end else begin
                            led_pos++;
                        end
                    end
                end
            end else begin
                tick_cnt = (tick_cnt + 1) & TICKS_MAX;
            end
        end
    endtask

    // Register writes go straight into the shadow copy at the edge that
    // takes them. The write enable is lowered by the next transaction.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_NUM_LEDS:  m_num_leds = data[NUM_LEDS_W-1:0];
            CFG_ONE_HIGH:  m_one_hi   = data[TICK_W-1:0];
            CFG_ONE_LOW:   m_one_lo   = data[TICK_W-1:0];
            CFG_ZERO_HIGH: m_zero_hi  = data[TICK_W-1:0];
            CFG_ZERO_LOW:  m_zero_lo  = data[TICK_W-1:0];
            default: ;
        endcase
    endtask

    // Holds the command port quiet until every result is home and the
    // store is no longer being swept or read for the next LED.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_levels.size() != 0)
            @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
    endtask

    // Offers one transaction after a random gap, or at once when no_idle is set,
    // waits for the edge that takes it, then books its expected result.
    task automatic run_item(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                            input logic [PIX_W-1:0] colour, input bit known,
                            input t_strip_res want, input bit no_idle);
        t_strip_res  predicted;
        int unsigned gap;
        i_cfg_we <= 1'b0;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_func      <= fn;
        i_led_index <= idx;
        i_red       <= colour[23:16];
        i_green     <= colour[15:8];
        i_blue      <= colour[7:0];
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        predict_strip_tick(fn, idx, colour, predicted);
        pending_levels.push_back(known ? want : predicted);
    endtask

    task automatic add_reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
        t_plan_row row;
        row = '{default: '0};
        row.is_reg   = 1'b1;
        row.reg_idx  = idx;
        row.reg_data = data;
        test_plan.push_back(row);
    endtask

    task automatic add_item_row(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                                input logic [PIX_W-1:0] colour);
        t_plan_row row;
        row = '{default: '0};
        row.fn     = fn;
        row.idx    = idx;
        row.colour = colour;
        test_plan.push_back(row);
    endtask

    task automatic add_check_row(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] idx,
                                 input logic [PIX_W-1:0] colour,
                                 input logic line, input logic shown, input logic rej);
        t_plan_row row;
        row = '{default: '0};
        row.fn     = fn;
        row.idx    = idx;
        row.colour = colour;
        row.known  = 1'b1;
        row.want   = '{data_line: line, show_busy: shown, rejected: rej};
        test_plan.push_back(row);
    endtask

    // Timing lengths are mostly a few ticks so that shows finish within a
    // phase; now and then a longer length or the maximum is written.
    function automatic logic [CFG_DW-1:0] pick_ticks();
        case ($urandom_range(0, 9))
            0:       return TICKS_MAX;
            1:       return CFG_DW'($urandom_range(5, 40));
            default: return CFG_DW'($urandom_range(0, 4));
        endcase
    endfunction

    task automatic program_setting();
        logic [CFG_DW-1:0] nl;
        case ($urandom_range(0, 19))
            0:          nl = '0;
            1:          nl = CFG_DW'(MAX_LEDS);
            2:          nl = CFG_DW'(MAX_LEDS - 1);
            3:          nl = CFG_DW'($urandom_range(MAX_LEDS + 1, 1023));
            4, 5, 6:    nl = CFG_DW'($urandom_range(4, 8));
            default:    nl = CFG_DW'($urandom_range(1, 3));
        endcase
        write_reg(CFG_NUM_LEDS, nl);
        write_reg(CFG_ONE_HIGH, pick_ticks());
        write_reg(CFG_ONE_LOW, pick_ticks());
        write_reg(CFG_ZERO_HIGH, pick_ticks());
        write_reg(CFG_ZERO_LOW, pick_ticks());
        if ($urandom_range(0, 9) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                      CFG_DW'($urandom));
    endtask

    // While a show runs most transactions are plain ticks that carry it
    // along; commands among the rest must bounce. Otherwise the mix
    // leans on setting LEDs inside the strip and starting shows.
    task automatic pick_item(output logic [FUNC_W-1:0] fn, output logic [IDX_W-1:0] idx,
                             output logic [PIX_W-1:0] colour);
        int unsigned roll;
        int unsigned count;
        count  = shown_leds();
        roll   = $urandom_range(0, 99);
        idx    = IDX_W'($urandom_range(0, 255));
        colour = PIX_W'($urandom);
        case ($urandom_range(0, 9))
            0:       colour = '0;
            1:       colour = '1;
            default: ;
        endcase
        if (show_on)
            fn = (roll < 75) ? FN_TICK : FUNC_W'($urandom_range(0, 7));
        else if (roll < 20)
            fn = FN_TICK;
        else if (roll < 50) begin
            fn = FN_SET;
            if (count != 0 && $urandom_range(0, 6) != 0)
                idx = IDX_W'($urandom_range(0, count - 1));
        end
        else if (roll < 58)
            fn = FN_SET_ALL;
        else if (roll < 63)
            fn = FN_ALL_ON;
        else if (roll < 68)
            fn = FN_CLEAR;
        else if (roll < 93)
            fn = FN_SHOW;
        else if (roll < 96)
            fn = FN_SPARE_6;
        else
            fn = FN_SPARE_7;
    endtask

    // Result checker. The receiver cannot stall, so every strobe is a
    // transaction that must match the oldest booked result.
    always @(posedge i_clk) begin : result_check
        t_strip_res seen;
        t_strip_res want;
        if (i_rst_n && o_valid === 1'b1) begin
            seen = '{data_line: o_data_line, show_busy: o_busy_res, rejected: o_rejected};
            if (pending_levels.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result line=%b busy=%b rejected=%b",
                         $time, seen.data_line, seen.show_busy, seen.rejected);
            end else begin
                want = pending_levels.pop_front();
                if (seen !== want) begin
                    mismatches++;
                    $display("%0t: expected line=%b busy=%b rej=%b, got line=%b busy=%b rej=%b",
                             $time, want.data_line, want.show_busy, want.rejected,
                             seen.data_line, seen.show_busy, seen.rejected);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [FUNC_W-1:0] fn;
        logic [IDX_W-1:0]  idx;
        logic [PIX_W-1:0]  colour;
        int unsigned       random_sent;
        int unsigned       phase_len;
        bit                no_idle;

        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_func      = FN_TICK;
        i_led_index = '0;
        i_red       = '0;
        i_green     = '0;
        i_blue      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_NUM_LEDS;
        i_cfg_data  = '0;
        mismatches  = 0;
        cycles      = 0;
        random_sent = 0;

        // Shadow state after reset: an empty strip, a cleared store and
        // the default pulse timing.
        fill_leds('0, MAX_LEDS);
        show_on    = 1'b0;
        led_pos    = 0;
        bit_pos    = 0;
        phase_lo   = 1'b0;
        tick_cnt   = 0;
        m_num_leds = '0;
        m_one_hi   = ONE_HIGH_RST;
        m_one_lo   = ONE_LOW_RST;
        m_zero_hi  = ZERO_HIGH_RST;
        m_zero_lo  = ZERO_LOW_RST;

        // With no LEDs configured every command falls flat: a set colour is
        // always out of range, an empty show does not start, and the fill
        // commands have nothing to touch.
        add_check_row(FN_TICK,    8'd0,   24'h000000, 1'b0, 1'b0, 1'b0);
        add_check_row(FN_SET,     8'd0,   24'hFFFFFF, 1'b0, 1'b0, 1'b1);
        add_check_row(FN_SET,     8'd255, 24'h5A5A5A, 1'b0, 1'b0, 1'b1);
        add_check_row(FN_SHOW,    8'd0,   24'h000000, 1'b0, 1'b0, 1'b0);
        add_check_row(FN_SPARE_6, 8'hFF,  24'hFFFFFF, 1'b0, 1'b0, 1'b0);
        add_check_row(FN_SPARE_7, 8'hAA,  24'h555555, 1'b0, 1'b0, 1'b0);
        add_check_row(FN_SET_ALL, 8'd0,   24'hFFFFFF, 1'b0, 1'b0, 1'b0);
        add_check_row(FN_ALL_ON,  8'd0,   24'h000000, 1'b0, 1'b0, 1'b0);
        add_check_row(FN_CLEAR,   8'd0,   24'h000000, 1'b0, 1'b0, 1'b0);
        // A count beyond the store depth is clipped to the full store, so
        // the top LED is in range. Bit 9 of the data is not part of it.
        add_reg_row(CFG_NUM_LEDS, 10'h3FF);
        add_check_row(FN_SET,     8'd255, 24'h123456, 1'b0, 1'b0, 1'b0);
        add_check_row(FN_SET_ALL, 8'd0,   24'hA5A5A5, 1'b0, 1'b0, 1'b0);
        add_check_row(FN_CLEAR,   8'd0,   24'h000000, 1'b0, 1'b0, 1'b0);
        add_check_row(FN_ALL_ON,  8'd0,   24'h000000, 1'b0, 1'b0, 1'b0);
        add_reg_row(CFG_NUM_LEDS, 10'd256);
        add_check_row(FN_SET,     8'd255, 24'hFFFFFF, 1'b0, 1'b0, 1'b0);
        // A short strip with fast timing; a zero length acts as one tick.
        add_reg_row(CFG_NUM_LEDS, 10'd2);
        add_check_row(FN_SET,     8'd2,   24'hFFFFFF, 1'b0, 1'b0, 1'b1);
        add_item_row(FN_SET,      8'd1,   24'h00FF00);
        add_item_row(FN_SET,      8'd0,   24'h800001);
        add_reg_row(CFG_ONE_HIGH, 10'd2);
        add_reg_row(CFG_ONE_LOW, 10'd1);
        add_reg_row(CFG_ZERO_HIGH, 10'd0);
        add_reg_row(CFG_ZERO_LOW, 10'd3);
        // The show drives its first high tick at once; every command after
        // it bounces while the show is still running.
        add_check_row(FN_SHOW,    8'd0,   24'h000000, 1'b1, 1'b1, 1'b0);
        add_item_row(FN_SET,      8'd0,   24'h000000);
        add_item_row(FN_SET_ALL,  8'd0,   24'hFFFFFF);
        add_item_row(FN_ALL_ON,   8'd0,   24'h000000);
        add_item_row(FN_CLEAR,    8'd0,   24'h000000);
        add_item_row(FN_SHOW,     8'd0,   24'h000000);
        // A timing change in the middle of a show takes effect at once.
        add_reg_row(CFG_ZERO_LOW, TICKS_MAX);
        add_reg_row(CFG_SPARE_HI, TICKS_MAX);
        add_item_row(FN_SPARE_7,  8'd0,   24'h000000);
        add_item_row(FN_TICK,     8'd0,   24'h000000);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (test_plan[r]) begin
            if (test_plan[r].is_reg) begin
                wait_idle();
                write_reg(test_plan[r].reg_idx, test_plan[r].reg_data);
            end else begin
                run_item(test_plan[r].fn, test_plan[r].idx, test_plan[r].colour,
                         test_plan[r].known, test_plan[r].want, 1'b0);
            end
        end

        // Random phases, each with a fresh setting. A show left running at
        // the end of a phase carries on under the new setting.
        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            program_setting();
            no_idle   = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 200);
            repeat (phase_len) begin
                pick_item(fn, idx, colour);
                run_item(fn, idx, colour, 1'b0, '0, no_idle);
                random_sent++;
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_levels.size() != 0) begin
            mismatches += pending_levels.size();
            $display("%0t: %0d results never arrived", $time, pending_levels.size());
        end
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ rgb_led_strip_serializer_core.f @@
rtl/rgb_ls_pkg.sv
rtl/rgb_ls_ctrl.sv
rtl/rgb_ls_dp.sv
rtl/rgb_led_strip_serializer_core.sv
rtl/rgb_ls_checker.sv
tb/rgb_led_strip_serializer_core_tb.sv
